// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scorer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define SBLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define SBLS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SBLS_ASSERT(lbl, prop, msg)
`define SBLS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/sbls_pkg.sv =====
// Shared types and fixed widths of the sparse bilinear latent scorer.
// No dependencies; imported by the controller, the datapath and the top level.
package sbls_pkg;

  localparam int REQ_W      = 2;
  localparam int FEAT_W     = 12;
  localparam int POS_W      = 4;
  localparam int VAL_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 5;
  localparam int LIN_BITS   = 32;
  localparam int FRAC_BITS  = 11;
  localparam int SCORE_BITS = 48;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_AD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_USER = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAT_DIM  = 2'd2;

  localparam logic [DIM_W-1:0] LAT_DIM_RST = 5'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_LIN = 2'd0,
    REQ_WR_LAT = 2'd1,
    REQ_FEAT   = 2'd2,
    REQ_END    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN,
    S_ROW,
    S_DRAIN,
    S_SETUP,
    S_DOT,
    S_DOT_WAIT,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic wr_lin;
    logic wr_lat;
    logic latch_feat;
    logic lin_rd;
    logic lat_rd;
    logic clr_cnt;
    logic inc_cnt;
    logic acc_init;
    logic mul_en;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic lat_hit;
    logic n_zero;
    logic cnt_last;
    logic last;
  } dp_status_t;

endpackage

// ===== rtl/sbls_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module sbls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sbls_ctrl.sv =====
// Sequencing controller of the scorer: accepts items and steps the datapath.
// Depends on sbls_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbls_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sbls_pkg::REQ_W-1:0]  req_type_i,
  input  sbls_pkg::dp_status_t        status_i,
  output sbls_pkg::dp_cmd_t           cmd_o,
  output logic                        busy_o
);
  import sbls_pkg::*;

  ctrl_state_e state_q, state_d;
  req_e        req;

  assign req = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && req == REQ_FEAT) begin
          state_d = S_LIN;
        end else if (start_i && req == REQ_END) begin
          state_d = S_SETUP;
        end
      end
      S_LIN: begin
        state_d = (status_i.lat_hit && !status_i.n_zero) ? S_ROW : S_DRAIN;
      end
      S_ROW: begin
        if (status_i.cnt_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = status_i.last ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        state_d = status_i.n_zero ? S_DOT_WAIT : S_DOT;
      end
      S_DOT: begin
        if (status_i.cnt_last) begin
          state_d = S_DOT_WAIT;
        end
      end
      S_DOT_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.wr_lin     = start_i && req == REQ_WR_LIN;
        cmd_o.wr_lat     = start_i && req == REQ_WR_LAT;
        cmd_o.latch_feat = start_i && req == REQ_FEAT;
      end
      S_LIN: begin
        cmd_o.lin_rd  = 1'b1;
        cmd_o.clr_cnt = 1'b1;
      end
      S_ROW: begin
        cmd_o.lat_rd  = 1'b1;
        cmd_o.inc_cnt = 1'b1;
      end
      S_SETUP: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.clr_cnt  = 1'b1;
      end
      S_DOT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.inc_cnt = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `SBLS_ASSERT(a_emit_entry, state_q == S_EMIT |-> $past(state_q) == S_DOT_WAIT, "emit not after dot drain")
  `SBLS_ASSERT(a_row_hit, state_q == S_ROW |-> (status_i.lat_hit && !status_i.n_zero), "row walk without latent row")
  `SBLS_ASSERT(a_setup_entry, state_q == S_SETUP |-> ($past(state_q) == S_IDLE || $past(state_q) == S_DRAIN), "bad entry into score setup")

endmodule

// ===== rtl/sbls_dp.sv =====
// Datapath of the scorer: tables, configuration, latent sums, dot product.
// Depends on sbls_pkg, sbls_ram and assert_macros.svh.
`include "assert_macros.svh"
module sbls_dp #(
  parameter int FEATURE_SPACE = 4096,
  parameter int MAX_LATENT    = 16,
  parameter int WEIGHT_BITS   = 16,
  parameter int SUM_BITS      = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbls_pkg::dp_cmd_t                   cmd_i,
  output sbls_pkg::dp_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [sbls_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [sbls_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [sbls_pkg::FEAT_W-1:0]         feat_index_i,
  input  logic [sbls_pkg::POS_W-1:0]          latent_pos_i,
  input  logic signed [sbls_pkg::VAL_W-1:0]   weight_value_i,
  input  logic                                is_last_i,
  output logic                                result_valid_o,
  output logic signed [sbls_pkg::SCORE_BITS-1:0] score_o,
  output logic                                saturated_o
);
  import sbls_pkg::*;

  localparam int F_W   = $clog2(FEATURE_SPACE);
  localparam int K_W   = $clog2(MAX_LATENT);
  localparam int N_W   = $clog2(MAX_LATENT + 1);
  localparam int LA_W  = F_W + K_W;
  localparam int C_W   = ((F_W > CFG_DATA_W) ? F_W : CFG_DATA_W) + 2;
  localparam int AW    = ((SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS) + 1;
  localparam int LW    = ((LIN_BITS > WEIGHT_BITS) ? LIN_BITS : WEIGHT_BITS) + 1;
  localparam int P_W   = 2 * SUM_BITS;
  localparam int PM_W  = (P_W > LIN_BITS + FRAC_BITS) ? P_W : LIN_BITS + FRAC_BITS;
  localparam int ACC_R = PM_W + $clog2(MAX_LATENT + 1) + 1;
  localparam int ACC_W = (ACC_R > SCORE_BITS) ? ACC_R : SCORE_BITS + 1;

  localparam logic signed [LW-1:0] LIN_HI =
    {{(LW - LIN_BITS + 1){1'b0}}, {(LIN_BITS - 1){1'b1}}};
  localparam logic signed [LW-1:0] LIN_LO = ~LIN_HI;
  localparam logic signed [AW-1:0] SUM_HI =
    {{(AW - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [AW-1:0] SUM_LO = ~SUM_HI;
  localparam logic signed [ACC_W-1:0] SC_HI =
    {{(ACC_W - SCORE_BITS + 1){1'b0}}, {(SCORE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SC_LO = ~SC_HI;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] num_ad_q, num_user_q;
  logic [DIM_W-1:0]      latent_dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ad_q     <= '0;
      num_user_q   <= '0;
      latent_dim_q <= LAT_DIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_NUM_AD:   num_ad_q     <= cfg_data_i;
        CFG_NUM_USER: num_user_q   <= cfg_data_i;
        CFG_LAT_DIM:  latent_dim_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [N_W-1:0] n_dims;

  always_comb begin
    if (int'(latent_dim_q) > MAX_LATENT) begin
      n_dims = N_W'(MAX_LATENT);
    end else begin
      n_dims = N_W'(latent_dim_q);
    end
  end

  // Item fields, folded into the index space of the tables.
  logic [F_W-1:0]          f_in;
  logic [K_W-1:0]          pos_in;
  logic [WEIGHT_BITS-1:0]  w_in;

  assign f_in   = F_W'(feat_index_i);
  assign pos_in = K_W'(latent_pos_i);
  assign w_in   = WEIGHT_BITS'(weight_value_i);

  logic [F_W-1:0] f_q;
  logic           last_q, lat_ad_q, lat_user_q;
  logic [K_W-1:0] cnt_q, k_rd_q;
  logic           lin_vld_q, lat_vld_q, prod_vld_q;
  logic           in_ad, in_user;

  // The ad test comes first, so overlapping ranges count as ad.
  assign in_ad   = C_W'(f_in) < C_W'(num_ad_q);
  assign in_user = C_W'(f_in) < (C_W'(num_ad_q) + C_W'(num_user_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= 1'b0;
      lat_ad_q   <= 1'b0;
      lat_user_q <= 1'b0;
      cnt_q      <= '0;
      lin_vld_q  <= 1'b0;
      lat_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (cmd_i.latch_feat) begin
        last_q     <= is_last_i;
        lat_ad_q   <= in_ad;
        lat_user_q <= !in_ad && in_user;
      end
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.inc_cnt) begin
        cnt_q <= cnt_q + K_W'(1);
      end
      lin_vld_q  <= cmd_i.lin_rd;
      lat_vld_q  <= cmd_i.lat_rd;
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_feat) begin
      f_q <= f_in;
    end
    k_rd_q <= cnt_q;
  end

  assign status_o.lat_hit  = lat_ad_q || lat_user_q;
  assign status_o.n_zero   = (n_dims == '0);
  assign status_o.cnt_last = (N_W'(cnt_q) == (n_dims - N_W'(1)));
  assign status_o.last     = last_q;

  // Weight tables.
  logic [WEIGHT_BITS-1:0] lin_rdata_raw, lat_rdata_raw;

  sbls_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (FEATURE_SPACE)
  ) u_lin_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_lin),
    .waddr_i (f_in),
    .wdata_i (w_in),
    .re_i    (cmd_i.lin_rd),
    .raddr_i (f_q),
    .rdata_o (lin_rdata_raw)
  );

  sbls_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (FEATURE_SPACE * MAX_LATENT)
  ) u_lat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_lat),
    .waddr_i (LA_W'({f_in, pos_in})),
    .wdata_i (w_in),
    .re_i    (cmd_i.lat_rd),
    .raddr_i (LA_W'({f_q, cnt_q})),
    .rdata_o (lat_rdata_raw)
  );

  logic signed [WEIGHT_BITS-1:0] lin_rdata, lat_rdata;

  assign lin_rdata = $signed(lin_rdata_raw);
  assign lat_rdata = $signed(lat_rdata_raw);

  // Per-instance accumulators.
  logic signed [LIN_BITS-1:0] lin_sum_q, lin_sum_d;
  logic signed [SUM_BITS-1:0] ad_sum_q   [MAX_LATENT];
  logic signed [SUM_BITS-1:0] user_sum_q [MAX_LATENT];
  logic signed [SUM_BITS-1:0] elem_d;
  logic                       sat_seen_q;
  logic signed [LW-1:0]       lin_raw;
  logic signed [AW-1:0]       elem_raw;
  logic                       lin_ovf, elem_ovf;

  always_comb begin
    lin_raw = LW'(lin_sum_q) + LW'(lin_rdata);
    lin_ovf = (lin_raw > LIN_HI) || (lin_raw < LIN_LO);
    if (lin_raw > LIN_HI) begin
      lin_sum_d = LIN_HI[LIN_BITS-1:0];
    end else if (lin_raw < LIN_LO) begin
      lin_sum_d = LIN_LO[LIN_BITS-1:0];
    end else begin
      lin_sum_d = lin_raw[LIN_BITS-1:0];
    end
  end

  always_comb begin
    if (lat_ad_q) begin
      elem_raw = AW'(ad_sum_q[k_rd_q]) + AW'(lat_rdata);
    end else begin
      elem_raw = AW'(user_sum_q[k_rd_q]) + AW'(lat_rdata);
    end
    elem_ovf = (elem_raw > SUM_HI) || (elem_raw < SUM_LO);
    if (elem_raw > SUM_HI) begin
      elem_d = SUM_HI[SUM_BITS-1:0];
    end else if (elem_raw < SUM_LO) begin
      elem_d = SUM_LO[SUM_BITS-1:0];
    end else begin
      elem_d = elem_raw[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_sum_q  <= '0;
      sat_seen_q <= 1'b0;
      for (int i = 0; i < MAX_LATENT; i++) begin
        ad_sum_q[i]   <= '0;
        user_sum_q[i] <= '0;
      end
    end else if (cmd_i.emit) begin
      lin_sum_q  <= '0;
      sat_seen_q <= 1'b0;
      for (int i = 0; i < MAX_LATENT; i++) begin
        ad_sum_q[i]   <= '0;
        user_sum_q[i] <= '0;
      end
    end else begin
      if (lin_vld_q) begin
        lin_sum_q <= lin_sum_d;
      end
      if (lat_vld_q && lat_ad_q) begin
        ad_sum_q[k_rd_q] <= elem_d;
      end
      if (lat_vld_q && lat_user_q) begin
        user_sum_q[k_rd_q] <= elem_d;
      end
      if ((lin_vld_q && lin_ovf) || (lat_vld_q && elem_ovf)) begin
        sat_seen_q <= 1'b1;
      end
    end
  end

  // Dot product: one registered product per cycle into an exact accumulator.
  logic signed [P_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q;

  assign prod_d = ad_sum_q[cnt_q] * user_sum_q[cnt_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_init) begin
      acc_q <= ACC_W'($signed({lin_sum_q, {FRAC_BITS{1'b0}}}));
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Result register; the score saturates once, at the end.
  logic signed [SCORE_BITS-1:0] score_q;
  logic                         sat_out_q, res_vld_q;
  logic                         score_hi, score_lo;

  assign score_hi = acc_q > SC_HI;
  assign score_lo = acc_q < SC_LO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (score_hi) begin
        score_q <= SC_HI[SCORE_BITS-1:0];
      end else if (score_lo) begin
        score_q <= SC_LO[SCORE_BITS-1:0];
      end else begin
        score_q <= acc_q[SCORE_BITS-1:0];
      end
      sat_out_q <= sat_seen_q || score_hi || score_lo;
    end
  end

  assign result_valid_o = res_vld_q;
  assign score_o        = score_q;
  assign saturated_o    = sat_out_q;

  `SBLS_ASSERT(a_strobe_single, res_vld_q |=> !res_vld_q, "result strobe longer than one cycle")
  `SBLS_ASSERT(a_lat_class, lat_vld_q |-> (lat_ad_q || lat_user_q), "latent data without a target sum")
  `SBLS_ASSERT_RST(a_init_no_prod, !(cmd_i.acc_init && prod_vld_q), "product pending at score setup")

endmodule

// ===== rtl/sparse_bilinear_latent_score.sv =====
// Top level of the sparse bilinear latent scorer.
// Depends on sbls_pkg, sbls_ctrl, sbls_dp (which holds the sbls_ram tables).
//
// Items enter on start while busy is low; table writes leave busy low. A
// feature item keeps busy high for the linear read, a walk over the latent
// row when its index falls in the ad or user range and n is not zero, and a
// drain state, where n is latent_dim limited to MAX_LATENT: the latent table
// has one read port, so the row is fetched one element per cycle. The last
// feature, or an end item, then runs setup, the dot product and a wait and an
// emit state; it runs through one multiplier, one term per cycle. The score
// appears in the cycle after the emit state on score_o and saturated_o,
// marked by result_valid_o for exactly one cycle; there is no backpressure,
// so the receiver must take it then. Both weight tables are undefined after
// reset and are not cleared. FEATURE_SPACE and MAX_LATENT must be powers of
// two (MAX_LATENT at least 2). Configuration is written while busy is low.
module sparse_bilinear_latent_score #(
  parameter int FEATURE_SPACE = 4096,
  parameter int MAX_LATENT    = 16,
  parameter int WEIGHT_BITS   = 16,
  parameter int SUM_BITS      = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [sbls_pkg::REQ_W-1:0]             req_type_i,
  input  logic [sbls_pkg::FEAT_W-1:0]            feat_index_i,
  input  logic [sbls_pkg::POS_W-1:0]             latent_pos_i,
  input  logic signed [sbls_pkg::VAL_W-1:0]      weight_value_i,
  input  logic                                   is_last_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sbls_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [sbls_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                   result_valid_o,
  output logic signed [sbls_pkg::SCORE_BITS-1:0] score_o,
  output logic                                   saturated_o
);
  import sbls_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy_int;

  sbls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_int)
  );

  sbls_dp #(
    .FEATURE_SPACE (FEATURE_SPACE),
    .MAX_LATENT    (MAX_LATENT),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .feat_index_i   (feat_index_i),
    .latent_pos_i   (latent_pos_i),
    .weight_value_i (weight_value_i),
    .is_last_i      (is_last_i),
    .result_valid_o (result_valid_o),
    .score_o        (score_o),
    .saturated_o    (saturated_o)
  );

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

endmodule
